/* sv/huffman_merge_cost_macros.svh */
// Assertion macros shared by the huffman_merge_cost RTL.
`ifndef HUFFMAN_MERGE_COST_MACROS_SVH
`define HUFFMAN_MERGE_COST_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HMC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HMC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/hmc_pkg.sv */
// Shared types and constants for the merge-cost block.
`default_nettype none

package hmc_pkg;

  localparam int WEIGHT_W        = 10;
  localparam int WEIGHT_CAP_W    = 16;
  localparam int VAL_W           = 20;
  localparam int COST_W          = 24;
  localparam int IN_DATA_W       = 16;
  localparam int OUT_DATA_W      = 24;
  localparam int DEF_MAX_ITEMS   = 1024;
  localparam int DEF_MAX_WEIGHT  = 1000;

  localparam logic [VAL_W-1:0]  VAL_MAX  = {VAL_W{1'b1}};
  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_MERGE
  } op_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    op_t              op;
    logic [VAL_W-1:0] key;
  } cmd_t;

endpackage

`default_nettype wire

/* sv/hmc_cell.sv */
// One cell of the sorted chain: holds one value, ascending order along the chain.
`default_nettype none

module hmc_cell
  import hmc_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 11
) (
  input  wire logic             clk,
  input  wire cmd_t             cmd,
  input  wire logic [CNT_W-1:0] count,
  input  wire logic [VAL_W-1:0] prev_val,
  input  wire logic [VAL_W-1:0] next1_val,
  input  wire logic [VAL_W-1:0] next2_val,
  output logic      [VAL_W-1:0] val
);

  localparam bit              HAS_PREV = (IDX > 0);
  localparam logic [CNT_W:0]  IDX_SELF = (CNT_W+1)'(IDX);
  localparam logic [CNT_W:0]  IDX_PREV = (CNT_W+1)'((IDX > 0) ? IDX - 1 : 0);
  localparam logic [CNT_W:0]  IDX_P1   = (CNT_W+1)'(IDX + 1);
  localparam logic [CNT_W:0]  IDX_P2   = (CNT_W+1)'(IDX + 2);

  logic [CNT_W:0]   cnt_x;
  logic [VAL_W-1:0] cand_prev;
  logic [VAL_W-1:0] cand_self;
  logic             occ_prev;
  logic             occ_self;
  logic [VAL_W-1:0] val_next;

  assign cnt_x = {1'b0, count};

  // Merge drops the two head entries: the list seen here shifts left by two.
  always_comb begin
    if (cmd.op == OP_MERGE) begin
      cand_prev = next1_val;
      cand_self = next2_val;
      occ_prev  = HAS_PREV && (cnt_x > IDX_P1);
      occ_self  = cnt_x > IDX_P2;
    end else begin
      cand_prev = prev_val;
      cand_self = val;
      occ_prev  = HAS_PREV && (cnt_x > IDX_PREV);
      occ_self  = cnt_x > IDX_SELF;
    end
  end

  always_comb begin
    unique case (cmd.op)
      OP_INSERT, OP_MERGE: begin
        if (occ_prev && (cmd.key < cand_prev)) begin
          val_next = cand_prev;
        end else if (!occ_self || (cmd.key < cand_self)) begin
          val_next = cmd.key;
        end else begin
          val_next = cand_self;
        end
      end
      default: begin
        val_next = val;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

`default_nettype wire

/* sv/hmc_chain.sv */
// Row of sorted-list cells; each cell sees its left neighbor and two right neighbors.
`default_nettype none

module hmc_chain
  import hmc_pkg::*;
#(
  parameter int MAX_ITEMS = DEF_MAX_ITEMS,
  parameter int CNT_W     = $clog2(MAX_ITEMS + 1)
) (
  input  wire logic             clk,
  input  wire cmd_t             cmd,
  input  wire logic [CNT_W-1:0] count,
  output logic      [VAL_W-1:0] head0,
  output logic      [VAL_W-1:0] head1
);

  logic [VAL_W-1:0] vals [MAX_ITEMS];

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic [VAL_W-1:0] prev_v;
    logic [VAL_W-1:0] next1_v;
    logic [VAL_W-1:0] next2_v;

    if (i > 0) begin : g_prev
      assign prev_v = vals[i-1];
    end else begin : g_no_prev
      assign prev_v = '0;
    end

    if (i + 1 < MAX_ITEMS) begin : g_n1
      assign next1_v = vals[i+1];
    end else begin : g_no_n1
      assign next1_v = '0;
    end

    if (i + 2 < MAX_ITEMS) begin : g_n2
      assign next2_v = vals[i+2];
    end else begin : g_no_n2
      assign next2_v = '0;
    end

    hmc_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .count     (count),
      .prev_val  (prev_v),
      .next1_val (next1_v),
      .next2_val (next2_v),
      .val       (vals[i])
    );
  end

  assign head0 = vals[0];
  assign head1 = vals[1];

endmodule

`default_nettype wire

/* sv/huffman_merge_cost.sv */
// Minimum total merge cost (Huffman path length) over a run of weights.
//
// Input channel s_*: one weight per beat, s_tlast marks the final weight of a run.
// Output channel m_*: one beat per run, total cost in m_tdata, overflow in m_tuser.
// Weights are kept in a sorted chain of MAX_ITEMS cells, smallest at the head.
// Each weight beat is inserted into the chain as it is taken; s_tready stays high
// until the last beat of a run. Then each merge runs S_SUM (add the two head values)
// and S_INS (drop them and insert the sum across the chain) until one value is left,
// and the result is loaded from S_DONE.
// A weight that arrives with all MAX_ITEMS cells full is dropped and flags overflow.
// Weights above MAX_WEIGHT are clamped to it.
// The result waits in an output register; new weights are taken while it waits, but
// the next run's result is held back until m_tready takes the previous one.
// Reset (rst, synchronous) empties the chain and clears the cost and overflow flag;
// the block also clears itself after each result.
`default_nettype none
`include "huffman_merge_cost_macros.svh"

module huffman_merge_cost
  import hmc_pkg::*;
#(
  parameter int MAX_ITEMS  = DEF_MAX_ITEMS,
  parameter int MAX_WEIGHT = DEF_MAX_WEIGHT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [9:0] weight
  input  wire logic                  s_tlast,   // last_item
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic      [OUT_DATA_W-1:0] m_tdata,   // [23:0] total_cost
  output logic                       m_tuser    // overflow
);

  localparam int             CNT_W   = $clog2(MAX_ITEMS + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ITEMS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SUM,
    S_INS,
    S_DONE
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   count;
  logic [COST_W-1:0]  cost;
  logic               ovf;
  logic [VAL_W-1:0]   sum;

  cmd_t               cmd;
  logic [VAL_W-1:0]   head0;
  logic [VAL_W-1:0]   head1;
  logic               in_beat;
  logic               store_full;
  logic [VAL_W-1:0]   key_w;
  logic [VAL_W:0]     pair_sum;
  logic [VAL_W-1:0]   sum_next;
  logic [COST_W:0]    cost_sum;
  logic [COST_W-1:0]  cost_next;
  logic               out_free;

  assign s_tready   = (state == S_IDLE);
  assign in_beat    = s_tvalid && s_tready;
  assign store_full = (count == CNT_FULL);
  assign out_free   = !m_tvalid || m_tready;

  always_comb begin
    if (WEIGHT_CAP_W'(s_tdata[WEIGHT_W-1:0]) > WEIGHT_CAP_W'(MAX_WEIGHT)) begin
      key_w = VAL_W'(MAX_WEIGHT);
    end else begin
      key_w = VAL_W'(s_tdata[WEIGHT_W-1:0]);
    end
  end

  // Saturating adds: pair sum to the value width, running cost to the cost width.
  assign pair_sum  = {1'b0, head0} + {1'b0, head1};
  assign sum_next  = pair_sum[VAL_W] ? VAL_MAX : pair_sum[VAL_W-1:0];
  assign cost_sum  = {1'b0, cost} + (COST_W+1)'(sum);
  assign cost_next = cost_sum[COST_W] ? COST_MAX : cost_sum[COST_W-1:0];

  always_comb begin
    cmd.op  = OP_HOLD;
    cmd.key = key_w;
    if (in_beat && !store_full) begin
      cmd.op = OP_INSERT;
    end else if (state == S_INS) begin
      cmd.op  = OP_MERGE;
      cmd.key = sum;
    end
  end

  hmc_chain #(
    .MAX_ITEMS (MAX_ITEMS),
    .CNT_W     (CNT_W)
  ) u_chain (
    .clk   (clk),
    .cmd   (cmd),
    .count (count),
    .head0 (head0),
    .head1 (head1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      cost     <= '0;
      ovf      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // S_DONE reloads the output register itself
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_beat) begin
            if (store_full) begin
              ovf <= 1'b1;
            end else begin
              count <= count + 1'b1;
            end
            if (s_tlast) begin
              state <= S_SUM;
            end
          end
        end
        S_SUM: begin
          if (count > CNT_W'(1)) begin
            sum   <= sum_next;
            state <= S_INS;
          end else begin
            state <= S_DONE;
          end
        end
        S_INS: begin
          cost  <= cost_next;
          count <= count - 1'b1;
          state <= S_SUM;
        end
        S_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= OUT_DATA_W'(cost);
            m_tuser  <= ovf;
            count    <= '0;
            cost     <= '0;
            ovf      <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `HMC_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_FULL, "chain count above capacity")
  `HMC_ASSERT_NOW(a_head_sorted, clk, rst, (state == S_SUM) && (count > CNT_W'(1)), head0 <= head1, "chain head out of order")
  `HMC_ASSERT_NEXT(a_merge_shrinks, clk, rst, state == S_INS, count == CNT_W'($past(count) - 1'b1), "merge did not drop one entry")
  `HMC_ASSERT_NEXT(a_done_clears, clk, rst, (state == S_DONE) && out_free, m_tvalid && (count == '0) && (cost == '0) && !ovf, "result load did not clear the run")

endmodule

`default_nettype wire
